>>> rtl/core/simon_block_cipher_with_fault_injection_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Simon 32/64 block with fault injection
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SIMON_BLOCK_CIPHER_WITH_FAULT_INJECTION_TOP_MACROS_SVH
`define SIMON_BLOCK_CIPHER_WITH_FAULT_INJECTION_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIMFI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIMFI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/simfi_pkg.sv
// ----------------------------------------------------------------------------
// simfi_pkg
// Constants, types and control bundles shared by the Simon 32/64 block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package simfi_pkg;

    localparam int WORD_BITS    = 16;
    localparam int KEY_WORDS    = 4;
    localparam int TOTAL_ROUNDS = 32;

    // Constant folded into every generated round key (~3 on a 16-bit word).
    localparam logic [WORD_BITS-1:0] SCHED_CONST = 16'hFFFC;

    // The z0 sequence, element i in bit i; its period is 31.
    localparam logic [30:0] Z0_PERIOD = 31'b0110011100001101010010001011111;
    localparam logic [61:0] Z0_SEQ    = {Z0_PERIOD, Z0_PERIOD};

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        OP_ENCRYPT = 2'd0,
        OP_DECRYPT = 2'd1,
        OP_FAULT   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXPAND = 2'd1,
        ST_RUN    = 2'd2,
        ST_HOLD   = 2'd3
    } state_t;

    // Shift control for the round key ring.
    typedef struct packed {
        logic shift;
        logic dir_back;
    } ring_ctrl_t;

    // Control for the Feistel round unit.
    typedef struct packed {
        logic  load;
        logic  step;
        logic  dec;
        logic  do_round;
        word_t flip_l;
        word_t flip_r;
    } round_ctrl_t;

endpackage

>>> rtl/core/simfi_key_cell.sv
// ----------------------------------------------------------------------------
// simfi_key_cell
// One round key cell of the ring; shifts forward or backward on command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simfi_key_cell (
    input  logic                  aclk,
    input  simfi_pkg::ring_ctrl_t ctrl,
    input  simfi_pkg::word_t      fwd_in,
    input  simfi_pkg::word_t      back_in,
    output simfi_pkg::word_t      key_q
);

    simfi_pkg::word_t key_reg;
    simfi_pkg::word_t key_next;

    always_comb begin
        key_next = key_reg;
        if (ctrl.shift) begin
            key_next = ctrl.dir_back ? back_in : fwd_in;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;

endmodule

>>> rtl/core/simfi_round.sv
// ----------------------------------------------------------------------------
// simfi_round
// Feistel round unit holding the two block halves, with bit fault insertion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simfi_round (
    input  logic                   aclk,
    input  simfi_pkg::round_ctrl_t ctrl,
    input  simfi_pkg::word_t       left_in,
    input  simfi_pkg::word_t       right_in,
    input  simfi_pkg::word_t       round_key,
    output simfi_pkg::word_t       left_q,
    output simfi_pkg::word_t       right_q
);

    // F(x) = (x <<< 1 & x <<< 8) ^ x <<< 2
    function automatic simfi_pkg::word_t round_f(input simfi_pkg::word_t x);
        round_f = ({x[14:0], x[15]} & {x[7:0], x[15:8]}) ^ {x[13:0], x[15:14]};
    endfunction

    simfi_pkg::word_t l_reg, l_next;
    simfi_pkg::word_t r_reg, r_next;
    simfi_pkg::word_t l_flip, r_flip;

    always_comb begin
        l_flip = l_reg ^ ctrl.flip_l;
        r_flip = r_reg ^ ctrl.flip_r;
        l_next = l_reg;
        r_next = r_reg;
        if (ctrl.load) begin
            l_next = left_in;
            r_next = right_in;
        end else if (ctrl.step) begin
            l_next = l_flip;
            r_next = r_flip;
            if (ctrl.do_round) begin
                if (ctrl.dec) begin
                    r_next = l_flip ^ round_f(r_flip) ^ round_key;
                    l_next = r_flip;
                end else begin
                    l_next = r_flip ^ round_f(l_flip) ^ round_key;
                    r_next = l_flip;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        l_reg <= l_next;
        r_reg <= r_next;
    end

    assign left_q  = l_reg;
    assign right_q = r_reg;

endmodule

>>> rtl/core/simon_block_cipher_with_fault_injection_top.sv
// ----------------------------------------------------------------------------
// simon_block_cipher_with_fault_injection_top
// Simon 32/64 encrypt, decrypt and single-bit fault encrypt on a stream.
// ----------------------------------------------------------------------------
// The block takes one beat at a time and returns exactly one result beat for
// each. An item passes from its accept through the run state of the round
// unit (one Feistel round per cycle over the 32-cell round key ring, plus a
// final slot for a fault placed after the last round) to the hold state,
// which moves the halves into the output register. The ring always turns a
// full revolution per item so that round key zero is back at its head
// afterwards. The first item after reset or after any key register write
// first runs a key expansion through the same ring before its rounds. A new
// beat is accepted once the previous result sits in the output register,
// even if the downstream side has not taken it yet; back pressure beyond
// that holds the finished halves in the round unit. The user must write key
// registers only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps

module simon_block_cipher_with_fault_injection_top (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: key_word_0..key_word_3 at indexes 0..3.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: left_word[15:0], right_word[31:16], round_count[37:32],
    //          flt_round[43:38], fault_position[49:44], zero fill [55:50]
    input  logic [55:0] s_tdata,
    // s_tuser: operation[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: left_out[15:0], right_out[31:16]
    output logic [31:0] m_tdata
);

    localparam logic [5:0] ROUNDS_6 = 6'(simfi_pkg::TOTAL_ROUNDS);
    localparam logic [5:0] KEYS_6   = 6'(simfi_pkg::KEY_WORDS);
    localparam logic [5:0] LAST_EXP = 6'(simfi_pkg::TOTAL_ROUNDS - 1);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Next round key from k[i-1], k[i-3], k[i-4] and the z0 bit.
    function automatic simfi_pkg::word_t sched_word(
        input simfi_pkg::word_t k1,
        input simfi_pkg::word_t k3,
        input simfi_pkg::word_t k4,
        input logic             zbit
    );
        simfi_pkg::word_t t;
        t = {k1[2:0], k1[15:3]} ^ k3;
        t = t ^ {t[0], t[15:1]};
        sched_word = k4 ^ {15'd0, zbit} ^ t ^ simfi_pkg::SCHED_CONST;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    simfi_pkg::state_t state_reg, state_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              keys_ready_reg, keys_ready_next;
    simfi_pkg::word_t  key_reg [simfi_pkg::KEY_WORDS];

    logic              dec_reg, fault_reg;
    logic [5:0]        pre_reg, total_reg;
    simfi_pkg::word_t  flip_l_reg, flip_r_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    simfi_pkg::word_t  m_left_reg, m_right_reg;

    // ------------------------------------------------------------------
    // Input beat decode
    // ------------------------------------------------------------------
    logic              s_accept;
    simfi_pkg::op_t    in_op;
    logic [5:0]        in_rc, in_fr, in_fp;
    logic [5:0]        rc_sat, pre_raw, pre_sat, total_in;
    logic [5:0]        fp_left_sh, fp_right_sh;
    simfi_pkg::word_t  mask_l, mask_r;

    assign s_accept = s_tvalid && s_tready;
    assign in_op    = simfi_pkg::op_t'(s_tuser);
    assign in_rc    = s_tdata[37:32];
    assign in_fr    = s_tdata[43:38];
    assign in_fp    = s_tdata[49:44];

    always_comb begin
        rc_sat   = (in_rc > ROUNDS_6) ? ROUNDS_6 : in_rc;
        pre_raw  = (in_fr == 6'd0) ? 6'd0 : in_fr - 6'd1;
        pre_sat  = (pre_raw > ROUNDS_6) ? ROUNDS_6 : pre_raw;
        // A fault placed past the requested rounds still runs up to it.
        total_in = ((in_op == simfi_pkg::OP_FAULT) && (pre_sat > rc_sat))
                 ? pre_sat : rc_sat;

        fp_left_sh  = in_fp - 6'd1;
        fp_right_sh = in_fp - 6'd17;
        mask_l = '0;
        mask_r = '0;
        if (in_fp >= 6'd1 && in_fp <= 6'd16) begin
            mask_l = simfi_pkg::word_t'(1) << fp_left_sh[3:0];
        end else if (in_fp >= 6'd17 && in_fp <= 6'd32) begin
            mask_r = simfi_pkg::word_t'(1) << fp_right_sh[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dec_reg    <= (in_op == simfi_pkg::OP_DECRYPT);
            fault_reg  <= (in_op == simfi_pkg::OP_FAULT);
            pre_reg    <= pre_sat;
            total_reg  <= total_in;
            flip_l_reg <= mask_l;
            flip_r_reg <= mask_r;
        end
    end

    // ------------------------------------------------------------------
    // Round key ring: 32 cells, cell 0 holds round key zero when at rest.
    // Forward shifts move cell i+1 into cell i; backward the reverse.
    // ------------------------------------------------------------------
    simfi_pkg::word_t     cell_q [simfi_pkg::TOTAL_ROUNDS];
    simfi_pkg::word_t     ring_in;
    simfi_pkg::ring_ctrl_t ring_ctrl;
    simfi_pkg::word_t     exp_word;
    logic [5:0]           z_idx;

    assign z_idx = cnt_reg - KEYS_6;

    always_comb begin
        if (cnt_reg < KEYS_6) begin
            exp_word = key_reg[cnt_reg[1:0]];
        end else begin
            exp_word = sched_word(cell_q[simfi_pkg::TOTAL_ROUNDS-1],
                                  cell_q[simfi_pkg::TOTAL_ROUNDS-3],
                                  cell_q[simfi_pkg::TOTAL_ROUNDS-4],
                                  simfi_pkg::Z0_SEQ[z_idx]);
        end
    end

    assign ring_in = (state_reg == simfi_pkg::ST_EXPAND) ? exp_word : cell_q[0];

    assign ring_ctrl.shift    = (state_reg == simfi_pkg::ST_EXPAND)
                             || ((state_reg == simfi_pkg::ST_RUN) && !cnt_reg[5]);
    assign ring_ctrl.dir_back = (state_reg == simfi_pkg::ST_RUN) && dec_reg;

    for (genvar gi = 0; gi < simfi_pkg::TOTAL_ROUNDS; gi++) begin : g_ring
        simfi_key_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ring_ctrl),
            .fwd_in  ((gi == simfi_pkg::TOTAL_ROUNDS - 1)
                      ? ring_in : cell_q[(gi + 1) % simfi_pkg::TOTAL_ROUNDS]),
            .back_in (cell_q[(gi + simfi_pkg::TOTAL_ROUNDS - 1) % simfi_pkg::TOTAL_ROUNDS]),
            .key_q   (cell_q[gi])
        );
    end

    // ------------------------------------------------------------------
    // Round unit. Encryption reads the ring head, decryption its tail.
    // In cycle n the fault (if due at n) is applied, then round n runs if
    // n is below the round total.
    // ------------------------------------------------------------------
    simfi_pkg::round_ctrl_t round_ctrl;
    simfi_pkg::word_t       round_key, blk_l, blk_r;
    logic                   flip_now;

    assign flip_now            = fault_reg && (cnt_reg == pre_reg);
    assign round_ctrl.load     = s_accept;
    assign round_ctrl.step     = (state_reg == simfi_pkg::ST_RUN);
    assign round_ctrl.dec      = dec_reg;
    assign round_ctrl.do_round = (cnt_reg < total_reg);
    assign round_ctrl.flip_l   = flip_now ? flip_l_reg : '0;
    assign round_ctrl.flip_r   = flip_now ? flip_r_reg : '0;
    assign round_key = dec_reg ? cell_q[simfi_pkg::TOTAL_ROUNDS-1] : cell_q[0];

    simfi_round u_round (
        .aclk      (aclk),
        .ctrl      (round_ctrl),
        .left_in   (s_tdata[15:0]),
        .right_in  (s_tdata[31:16]),
        .round_key (round_key),
        .left_q    (blk_l),
        .right_q   (blk_r)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_load;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        keys_ready_next = keys_ready_reg;
        out_load        = 1'b0;
        s_tready        = 1'b0;
        case (state_reg)
            simfi_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cnt_next = 6'd0;
                if (s_accept) begin
                    state_next = keys_ready_reg ? simfi_pkg::ST_RUN
                                                : simfi_pkg::ST_EXPAND;
                end
            end
            simfi_pkg::ST_EXPAND: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_EXP) begin
                    cnt_next        = 6'd0;
                    keys_ready_next = 1'b1;
                    state_next      = simfi_pkg::ST_RUN;
                end
            end
            simfi_pkg::ST_RUN: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == ROUNDS_6) begin
                    cnt_next   = 6'd0;
                    state_next = simfi_pkg::ST_HOLD;
                end
            end
            simfi_pkg::ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = simfi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = simfi_pkg::ST_IDLE;
            end
        endcase
        // Any key write invalidates the expanded table.
        if (cfg_wr_en) begin
            keys_ready_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= simfi_pkg::ST_IDLE;
            cnt_reg        <= 6'd0;
            keys_ready_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            keys_ready_reg <= keys_ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < simfi_pkg::KEY_WORDS; k++) begin
                key_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            key_reg[cfg_index] <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_left_reg  <= blk_l;
            m_right_reg <= blk_r;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_right_reg, m_left_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "simon_block_cipher_with_fault_injection_top_macros.svh"

    `SIMFI_ASSERT_NEXT(a_key_write_clears, cfg_wr_en, !keys_ready_reg, "key write left table marked ready")
    `SIMFI_ASSERT_NEXT(a_cold_start_expands, s_accept && !keys_ready_reg, state_reg == simfi_pkg::ST_EXPAND, "stale keys did not trigger expansion")
    `SIMFI_ASSERT_NEXT(a_expand_to_run, (state_reg == simfi_pkg::ST_EXPAND) && (cnt_reg == LAST_EXP), state_reg == simfi_pkg::ST_RUN, "expansion did not hand over to rounds")
    `SIMFI_ASSERT_SAME(a_run_count_bound, state_reg == simfi_pkg::ST_RUN, cnt_reg <= ROUNDS_6, "round counter ran past the last slot")

endmodule

>>> bench/tb_simon_block_cipher_with_fault_injection_top.sv
// ----------------------------------------------------------------------------
// Simon 32/64 fault injection block testbench
// Streams encrypt, decrypt and fault-encrypt requests through the block under
// several key settings and checks each result beat against a behavioral
// Simon 32/64 computation kept inside this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_simon_block_cipher_with_fault_injection_top;

    // The operation code that the block treats as a plain encryption.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Key register indexes on the configuration port.
    localparam logic [1:0] REG_KEY_WORD_0 = 2'd0;
    localparam logic [1:0] REG_KEY_WORD_1 = 2'd1;
    localparam logic [1:0] REG_KEY_WORD_2 = 2'd2;
    localparam logic [1:0] REG_KEY_WORD_3 = 2'd3;

    // Constant folded into every generated round key: ~3 on a 16-bit word.
    localparam simfi_pkg::word_t KEY_SCHED_CONST = 16'hFFFC;

    // The z0 sequence written in element order, element 0 leftmost. Only the
    // first 28 elements are used by the 32-round key schedule.
    localparam bit [0:30] Z0_BITS = 31'b1111101000100101011000011100110;

    // Idling rate per side, in percent, and the run limit in clock cycles.
    // The slowest item runs the key expansion as well as its rounds, plus
    // random gaps and stalls, and the limit still leaves a wide margin.
    localparam int IDLE_PCT    = 21;
    localparam int CYCLE_LIMIT = 500000;

    // One request: the operation travels on tuser, the rest on tdata.
    typedef struct packed {
        logic [1:0]       op;
        simfi_pkg::word_t left;
        simfi_pkg::word_t right;
        logic [5:0]       rounds;
        logic [5:0]       flt_round;
        logic [5:0]       fault_pos;
    } simon_req_t;

    // One cipher block, the two Feistel halves.
    typedef struct packed {
        simfi_pkg::word_t left;
        simfi_pkg::word_t right;
    } simon_blk_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // s_tdata: left_word[15:0], right_word[31:16], round_count[37:32],
    //          flt_round[43:38], fault_position[49:44], zero fill [55:50]
    logic [55:0] s_tdata   = 56'd0;
    // s_tuser: operation[1:0]
    logic [1:0]  s_tuser   = 2'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // m_tdata: left_out[15:0], right_out[31:16]
    logic [31:0] m_tdata;

    // Requests waiting for the driver, and cipher blocks still owed by the
    // block, oldest first.
    simon_req_t  request_q[$];
    simon_blk_t  cipher_out_q[$];

    // Bench copy of the key registers and the expanded round key schedule.
    simfi_pkg::word_t key_reg[simfi_pkg::KEY_WORDS];
    simfi_pkg::word_t round_key[simfi_pkg::TOTAL_ROUNDS];
    bit          round_keys_valid = 1'b0;

    // While set, neither side idles.
    bit          no_idle = 1'b0;
    int          error_count = 0;
    int          cycle_count = 0;

    simon_block_cipher_with_fault_injection_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 8 ns clock period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Simon 32/64 computation
    // ------------------------------------------------------------------

    // F(x) = (ROL1(x) & ROL8(x)) ^ ROL2(x)
    function automatic simfi_pkg::word_t simon_mix(simfi_pkg::word_t x);
        return ({x[14:0], x[15]} & {x[7:0], x[15:8]}) ^ {x[13:0], x[15:14]};
    endfunction

    // Rebuilds the 32 round keys from the four key registers. Each new key
    // combines the key four places back, the z0 bit, the schedule constant
    // and rotations of the keys one and three places back.
    function automatic void expand_round_keys();
        simfi_pkg::word_t t;
        for (int i = 0; i < simfi_pkg::KEY_WORDS; i++) begin
            round_key[i] = key_reg[i];
        end
        for (int i = simfi_pkg::KEY_WORDS; i < simfi_pkg::TOTAL_ROUNDS; i++) begin
            t = {round_key[i-1][2:0], round_key[i-1][15:3]} ^ round_key[i-3];
            t = t ^ {t[0], t[15:1]};
            round_key[i] = round_key[i-simfi_pkg::KEY_WORDS]
                           ^ simfi_pkg::word_t'(Z0_BITS[i-simfi_pkg::KEY_WORDS])
                           ^ t ^ KEY_SCHED_CONST;
        end
        round_keys_valid = 1'b1;
    endfunction

    // Computes the cipher block the block must return for one request. The
    // round key schedule is rebuilt first when a key register changed since
    // the last request, just as the block does on its first item.
    function automatic simon_blk_t simon_predict(simon_req_t req);
        simfi_pkg::word_t l;
        simfi_pkg::word_t r;
        int    rc;
        int    pre;
        int    fp;
        l  = req.left;
        r  = req.right;
        fp = int'(req.fault_pos);
        if (!round_keys_valid) begin
            expand_round_keys();
        end
        // Round counts beyond the full cipher saturate.
        rc = (req.rounds > simfi_pkg::TOTAL_ROUNDS) ? simfi_pkg::TOTAL_ROUNDS
                                                    : int'(req.rounds);
        if (req.op == simfi_pkg::OP_DECRYPT) begin
            // Decryption always starts from the last round key.
            for (int i = 0; i < rc; i++) begin
                {l, r} = {r, l ^ simon_mix(r) ^ round_key[simfi_pkg::TOTAL_ROUNDS-1-i]};
            end
        end else if (req.op == simfi_pkg::OP_FAULT) begin
            // Fault round zero behaves like fault round one; the number of
            // rounds ahead of the flip saturates at the full cipher, and the
            // rounds ahead of it run even past the round count.
            pre = (req.flt_round == 0) ? 0 : int'(req.flt_round) - 1;
            if (pre > simfi_pkg::TOTAL_ROUNDS) begin
                pre = simfi_pkg::TOTAL_ROUNDS;
            end
            for (int i = 0; i < pre; i++) begin
                {l, r} = {r ^ simon_mix(l) ^ round_key[i], l};
            end
            if (fp >= 1 && fp <= simfi_pkg::WORD_BITS) begin
                l = l ^ (simfi_pkg::word_t'(1) << (fp - 1));
            end else if (fp > simfi_pkg::WORD_BITS && fp <= 2 * simfi_pkg::WORD_BITS) begin
                r = r ^ (simfi_pkg::word_t'(1) << (fp - simfi_pkg::WORD_BITS - 1));
            end
            for (int i = pre; i < rc; i++) begin
                {l, r} = {r ^ simon_mix(l) ^ round_key[i], l};
            end
        end else begin
            // Plain encryption, also for the spare operation code.
            for (int i = 0; i < rc; i++) begin
                {l, r} = {r ^ simon_mix(l) ^ round_key[i], l};
            end
        end
        return '{left: l, right: r};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic bit idle_roll();
        return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic void queue_request(logic [1:0] op, simfi_pkg::word_t l,
                                          simfi_pkg::word_t r,
                                          logic [5:0] rc, logic [5:0] fr,
                                          logic [5:0] fp);
        request_q.insert(request_q.size(), '{op: op, left: l, right: r, rounds: rc,
                                             flt_round: fr, fault_pos: fp});
    endfunction

    // Random request. Most requests are well formed (valid operation, round
    // count up to 32, fault position on a real bit), with saturating counts,
    // the spare operation and dead fault positions mixed in.
    function automatic void queue_random_request();
        logic [1:0] op;
        logic [5:0] rc;
        logic [5:0] fr;
        logic [5:0] fp;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            op = simfi_pkg::OP_ENCRYPT;
        end else if (pick < 60) begin
            op = simfi_pkg::OP_DECRYPT;
        end else if (pick < 95) begin
            op = simfi_pkg::OP_FAULT;
        end else begin
            op = OP_SPARE;
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            rc = 6'($urandom_range(33, 63));
        end else if (pick < 30) begin
            rc = 6'(simfi_pkg::TOTAL_ROUNDS);
        end else begin
            rc = 6'($urandom_range(0, 31));
        end
        fr = ($urandom_range(0, 99) < 10) ? 6'($urandom_range(34, 63))
                                          : 6'($urandom_range(0, 33));
        fp = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(1, 32))
                                          : 6'($urandom_range(0, 63));
        queue_request(op, simfi_pkg::word_t'($urandom), simfi_pkg::word_t'($urandom),
                      rc, fr, fp);
    endfunction

    // One key register write. The bench copy changes with it and the round
    // key schedule is marked stale, so the next request rebuilds it.
    task automatic write_key(input logic [1:0] idx, input simfi_pkg::word_t val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        key_reg[idx]     = val;
        round_keys_valid = 1'b0;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_key_set(input simfi_pkg::word_t k0, input simfi_pkg::word_t k1,
                                 input simfi_pkg::word_t k2, input simfi_pkg::word_t k3);
        write_key(REG_KEY_WORD_0, k0);
        write_key(REG_KEY_WORD_1, k1);
        write_key(REG_KEY_WORD_2, k2);
        write_key(REG_KEY_WORD_3, k3);
    endtask

    // Waits until every queued request has gone in and every result beat has
    // come back; the block is idle from then on. Checked at the falling edge
    // so that all updates of the rising edge have settled.
    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || cipher_out_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: presents the next queued request at a rising edge and
    // holds it until the beat is taken. A random gap may fall between beats.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (request_q.size() != 0 && !idle_roll()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, request_q[0].fault_pos, request_q[0].flt_round,
                             request_q[0].rounds, request_q[0].right, request_q[0].left};
                s_tuser  <= request_q[0].op;
                void'(request_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted request beat is decoded from the bus and its
    // cipher block predicted; every accepted result beat is compared with
    // the oldest prediction. The result side stalls at random.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cipher_out_q.insert(cipher_out_q.size(), simon_predict('{
                    op: s_tuser, left: s_tdata[15:0], right: s_tdata[31:16],
                    rounds: s_tdata[37:32], flt_round: s_tdata[43:38],
                    fault_pos: s_tdata[49:44]}));
            end
            if (m_tvalid && m_tready) begin
                if (cipher_out_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with no request pending",
                                              m_tdata));
                end else begin
                    if (m_tdata[15:0] !== cipher_out_q[0].left) begin
                        report_mismatch($sformatf("left_out %h, expected %h",
                                                  m_tdata[15:0], cipher_out_q[0].left));
                    end
                    if (m_tdata[31:16] !== cipher_out_q[0].right) begin
                        report_mismatch($sformatf("right_out %h, expected %h",
                                                  m_tdata[31:16], cipher_out_q[0].right));
                    end
                    void'(cipher_out_q.pop_front());
                end
            end
            m_tready <= !idle_roll();
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_simon_block_cipher_with_fault_injection_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < simfi_pkg::KEY_WORDS; i++) begin
            key_reg[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the all-zero reset key. The first one also
        // triggers the key expansion straight after reset.
        queue_request(simfi_pkg::OP_ENCRYPT, 16'h0000, 16'h0000, 6'd32, 6'd0, 6'd0);
        queue_request(simfi_pkg::OP_ENCRYPT, 16'hFFFF, 16'hFFFF, 6'd32, 6'd0, 6'd0);
        queue_request(simfi_pkg::OP_DECRYPT, 16'hFFFF, 16'h0000, 6'd32, 6'd0, 6'd0);
        // Round counts above the full cipher saturate, zero rounds pass
        // the block through unchanged.
        queue_request(simfi_pkg::OP_DECRYPT, 16'h0000, 16'hFFFF, 6'd63, 6'd0, 6'd0);
        queue_request(simfi_pkg::OP_ENCRYPT, 16'h1234, 16'hABCD, 6'd0, 6'd0, 6'd0);
        queue_request(simfi_pkg::OP_ENCRYPT, 16'h1234, 16'hABCD, 6'd33, 6'd0, 6'd0);
        queue_request(simfi_pkg::OP_DECRYPT, 16'h8001, 16'h7FFE, 6'd1, 6'd0, 6'd0);
        // The spare operation code encrypts and ignores the fault fields.
        queue_request(OP_SPARE, 16'hA5A5, 16'h5A5A, 6'd20, 6'd3, 6'd7);
        // Fault round zero and one both hit before the first round; the
        // outer bits of both halves.
        queue_request(simfi_pkg::OP_FAULT, 16'h0F0F, 16'hF0F0, 6'd32, 6'd0, 6'd1);
        queue_request(simfi_pkg::OP_FAULT, 16'h0F0F, 16'hF0F0, 6'd32, 6'd1, 6'd16);
        queue_request(simfi_pkg::OP_FAULT, 16'h0F0F, 16'hF0F0, 6'd32, 6'd1, 6'd17);
        queue_request(simfi_pkg::OP_FAULT, 16'h0F0F, 16'hF0F0, 6'd32, 6'd16, 6'd32);
        // Fault rounds beyond the cipher saturate, so the flip lands after
        // the last round.
        queue_request(simfi_pkg::OP_FAULT, 16'h3C3C, 16'hC3C3, 6'd32, 6'd33, 6'd5);
        queue_request(simfi_pkg::OP_FAULT, 16'h3C3C, 16'hC3C3, 6'd32, 6'd63, 6'd20);
        // Fault placed past the round count: the rounds up to the fault
        // still run, then the flip, then nothing more.
        queue_request(simfi_pkg::OP_FAULT, 16'h6565, 16'h6877, 6'd10, 6'd20, 6'd3);
        queue_request(simfi_pkg::OP_FAULT, 16'h6565, 16'h6877, 6'd10, 6'd11, 6'd30);
        queue_request(simfi_pkg::OP_FAULT, 16'h6565, 16'h6877, 6'd0, 6'd0, 6'd9);
        // Positions that name no bit inject nothing.
        queue_request(simfi_pkg::OP_FAULT, 16'hDEAD, 16'hBEEF, 6'd32, 6'd5, 6'd0);
        queue_request(simfi_pkg::OP_FAULT, 16'hDEAD, 16'hBEEF, 6'd32, 6'd5, 6'd33);
        queue_request(simfi_pkg::OP_FAULT, 16'hDEAD, 16'hBEEF, 6'd32, 6'd5, 6'd63);
        queue_request(simfi_pkg::OP_FAULT, 16'hFFFF, 16'h0000, 6'd63, 6'd32, 6'd17);
        queue_request(simfi_pkg::OP_ENCRYPT, 16'h0000, 16'hFFFF, 6'd63, 6'd63, 6'd63);
        wait_drained();

        // Published Simon 32/64 key with its known plaintext and ciphertext.
        write_key_set(16'h0100, 16'h0908, 16'h1110, 16'h1918);
        queue_request(simfi_pkg::OP_ENCRYPT, 16'h6565, 16'h6877, 6'd32, 6'd0, 6'd0);
        queue_request(simfi_pkg::OP_DECRYPT, 16'hC69B, 16'hE9BB, 6'd32, 6'd0, 6'd0);
        repeat (155) queue_random_request();
        wait_drained();

        // All-ones key.
        write_key_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (155) queue_random_request();
        wait_drained();

        // Random key, with both sides running flat out throughout.
        write_key_set(simfi_pkg::word_t'($urandom), simfi_pkg::word_t'($urandom),
                      simfi_pkg::word_t'($urandom), simfi_pkg::word_t'($urandom));
        no_idle = 1'b1;
        repeat (155) queue_random_request();
        wait_drained();
        no_idle = 1'b0;

        // Changing part of the key must also force a fresh expansion.
        write_key(REG_KEY_WORD_2, simfi_pkg::word_t'($urandom));
        write_key(REG_KEY_WORD_0, 16'h0000);
        repeat (155) queue_random_request();
        wait_drained();

        // Allow a stray extra result beat time to show up.
        repeat (80) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_simon_block_cipher_with_fault_injection_top: clean");
        end else begin
            $display("tb_simon_block_cipher_with_fault_injection_top: errors");
        end
        $finish;
    end

endmodule
